// ----- hdl/wildcard_pattern_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// wildcard pattern matcher assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// same-cycle implication, disabled during reset
`define WPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard pattern matcher check failed");

// next-cycle implication, disabled during reset
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard pattern matcher check failed");

// next-cycle implication that also holds through reset
`define WPM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("wildcard pattern matcher check failed");

`endif

// ----- hdl/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types and constants of the wildcard pattern matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

   // largest supported pattern, in bytes
   localparam int MAX_PATTERN_DEFAULT = 32;

   // wildcard bytes
   localparam logic [7:0] STAR_CHAR     = 8'h2A;
   localparam logic [7:0] QUESTION_CHAR = 8'h3F;

   // operation carried with each input transaction
   typedef enum logic {
      OP_START = 1'b0,
      OP_CHAR  = 1'b1
   } op_type;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_PATTERN_WORD0  = 3'd0,
      REG_PATTERN_WORD1  = 3'd1,
      REG_PATTERN_WORD2  = 3'd2,
      REG_PATTERN_WORD3  = 3'd3,
      REG_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   // stored pattern: byte k at bits 8k+7:8k
   typedef struct packed {
      logic [255:0] pattern;
      logic [5:0]   length;
   } pattern_cfg_type;

   // one input item
   typedef struct packed {
      op_type     op;
      logic [7:0] text_char;
   } step_type;

   // one result item
   typedef struct packed {
      logic alive;
      logic matched;
   } result_type;

endpackage

// ----- hdl/wpm_csr_regs.sv -----
// ----------------------------------------------------------------------------
// wpm_csr_regs
// pattern and length registers written through the configuration port
// ----------------------------------------------------------------------------
module wpm_csr_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [63:0]              csr_data,
   output wpm_pkg::pattern_cfg_type cfg
);
   import wpm_pkg::*;

   logic [63:0] pattern_word_ff [4];
   logic [63:0] pattern_word_in [4];
   logic [5:0]  pattern_length_ff;
   logic [5:0]  pattern_length_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      pattern_word_in   = pattern_word_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PATTERN_WORD0:  pattern_word_in[0] = csr_data;
            REG_PATTERN_WORD1:  pattern_word_in[1] = csr_data;
            REG_PATTERN_WORD2:  pattern_word_in[2] = csr_data;
            REG_PATTERN_WORD3:  pattern_word_in[3] = csr_data;
            REG_PATTERN_LENGTH: pattern_length_in = csr_data[5:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_word_ff[0] <= '0;
         pattern_word_ff[1] <= '0;
         pattern_word_ff[2] <= '0;
         pattern_word_ff[3] <= '0;
         pattern_length_ff  <= '0;
      end else begin
         pattern_word_ff   <= pattern_word_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   // packed view of the pattern
   assign cfg.pattern = {pattern_word_ff[3], pattern_word_ff[2],
                         pattern_word_ff[1], pattern_word_ff[0]};
   assign cfg.length  = pattern_length_ff;

endmodule

// ----- hdl/wpm_column_unit.sv -----
// ----------------------------------------------------------------------------
// wpm_column_unit
// match column register and its single-pass update
// ----------------------------------------------------------------------------
module wpm_column_unit #(
   parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_valid,
   input  wpm_pkg::step_type        step,
   input  wpm_pkg::pattern_cfg_type cfg,
   output wpm_pkg::result_type      result
);
   import wpm_pkg::*;

   localparam int COL_W  = MAX_PATTERN + 1;
   localparam int IDX_W  = $clog2(COL_W);
   localparam int LEVELS = $clog2(COL_W);

   logic [COL_W-1:0] column_ff;
   logic [COL_W-1:0] column_in;
   logic [COL_W-1:0] gen;
   logic [COL_W-1:0] prop;
   logic [COL_W-1:0] col_mask;
   logic [COL_W-1:0] next_col;
   logic [COL_W-1:0] gen_lv  [0:LEVELS];
   logic [COL_W-1:0] prop_lv [0:LEVELS];
   logic [5:0]       used_len;
   logic [IDX_W-1:0] used_idx;
   logic [7:0]       pat_ch;

   // effective pattern length, clamped to MAX_PATTERN
   always_comb begin
      used_len = (cfg.length > 6'(MAX_PATTERN)) ? 6'(MAX_PATTERN) : cfg.length;
      used_idx = used_len[IDX_W-1:0];
   end

   // per-bit generate and propagate terms
   // a star passes the bit below upward, so the column is a carry chain
   always_comb begin
      gen    = '0;
      prop   = '0;
      pat_ch = '0;
      gen[0] = (step.op == OP_START);
      for (int i = 1; i < COL_W; i++) begin
         pat_ch  = cfg.pattern[8*(i-1) +: 8];
         prop[i] = (pat_ch == STAR_CHAR);
         if (step.op == OP_CHAR) begin
            if (pat_ch == STAR_CHAR) begin
               gen[i] = column_ff[i];
            end else if (pat_ch == QUESTION_CHAR || pat_ch == step.text_char) begin
               gen[i] = column_ff[i-1];
            end
         end
      end
   end

   // log-depth prefix over the star chain
   always_comb begin
      gen_lv[0]  = gen;
      prop_lv[0] = prop;
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int i = 0; i < COL_W; i++) begin
            if (i >= (1 << lv)) begin
               gen_lv[lv+1][i]  = gen_lv[lv][i]
                                | (prop_lv[lv][i] & gen_lv[lv][i - (1 << lv)]);
               prop_lv[lv+1][i] = prop_lv[lv][i] & prop_lv[lv][i - (1 << lv)];
            end else begin
               gen_lv[lv+1][i]  = gen_lv[lv][i];
               prop_lv[lv+1][i] = prop_lv[lv][i];
            end
         end
      end
   end

   // keep only prefixes up to the pattern length
   always_comb begin
      for (int i = 0; i < COL_W; i++) begin
         col_mask[i] = (6'(i) <= used_len);
      end
      next_col = gen_lv[LEVELS] & col_mask;
   end

   assign column_in = step_valid ? next_col : column_ff;

   // column state, empty text against empty pattern after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= COL_W'(1);
      end else begin
         column_ff <= column_in;
      end
   end

   // result of the item being processed
   assign result.matched = next_col[used_idx];
   assign result.alive   = |next_col;

endmodule

// ----- hdl/wildcard_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// path: a request transaction passes the input register and then the result
//    register on its way to its result transaction
// throughput: one item per cycle while the result channel does not stall, set by the single-pass column update
// reset: column holds only the empty prefix, pattern and length cleared
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
   parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic [0:0]  req_tuser,   // [0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] matched, [1] alive, [7:2] zero
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import wpm_pkg::*;

   pattern_cfg_type cfg;
   step_type        step_ff;
   step_type        step_in;
   logic            step_valid_ff;
   logic            step_valid_in;
   logic            advance;
   result_type      result;
   result_type      rsp_data_ff;
   result_type      rsp_data_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   // configuration registers
   wpm_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input stage moves on when the result register is free or drained
   assign advance    = step_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !step_valid_ff || advance;

   // input register
   always_comb begin
      step_in       = step_ff;
      step_valid_in = step_valid_ff;
      if (req_tvalid && req_tready) begin
         step_in.op        = op_type'(req_tuser[0]);
         step_in.text_char = req_tdata;
         step_valid_in     = 1'b1;
      end else if (advance) begin
         step_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff <= 1'b0;
      end else begin
         step_valid_ff <= step_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   // column update
   wpm_column_unit #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_column_unit (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step       (step_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.alive, rsp_data_ff.matched};

endmodule

// ----- hdl/wpm_checker.sv -----
// ----------------------------------------------------------------------------
// wpm_checker
// port-level checks of the wildcard pattern matcher, bound to the top level
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_macros.svh"

module wpm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a stalled result transaction holds its data
   `WPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a full match always leaves some prefix alive
   `WPM_ASSERT_SAME(a_match_alive, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[1])

   // no result right after reset
   `WPM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

   // a request taken while the result side is idle shows up after the input and result registers
   `WPM_ASSERT_NEXT(a_two_cycle, clock, reset, req_tvalid && req_tready && !rsp_tvalid, ##1 rsp_tvalid)

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// wildcard pattern matcher testbench
// drives start and text byte transactions against a range of stored glob
// patterns, predicts each match column in the bench and checks every
// matched and alive flag in order, with random idling on both streams
// ----------------------------------------------------------------------------
module testbench;
   import wpm_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int STALL_CYCLES  = 90;
   localparam int MAX_LEN       = 32;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_STEPS   = 122;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] text_char
   logic [0:0]  req_tuser  = '0;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] matched, [1] alive, [7:2] zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [63:0] csr_data   = '0;

   step_type   queued_steps[$];
   result_type expected_verdicts[$];
   int         fail_count     = 0;
   int         cycle_count    = 0;
   int         steps_queued   = 0;
   bit         calm           = 1'b0;
   int         stall_requests = 0;
   int         stall_served   = 0;
   int         stall_left     = 0;
   int         send_gap       = 0;
   int         sink_gap       = 0;

   // bench copy of the pattern registers and the match column
   logic [255:0] model_pattern = '0;
   logic [5:0]   model_length  = '0;
   logic [32:0]  match_bits    = 33'h1;

   // pattern as seen by the stimulus generator
   logic [255:0] stim_pattern = '0;
   int           stim_length  = 0;

   wildcard_pattern_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // next match column for one step, plus the flags it yields
   task automatic advance_column(input op_type op, input logic [7:0] ch,
                                 output result_type verdict);
      int          n;
      logic [32:0] next;
      logic [7:0]  pc;
      bit          leading;
      n = (model_length > MAX_LEN) ? MAX_LEN : int'(model_length);
      next = '0;
      if (op == OP_START) begin
         // empty text: prefix of leading stars only
         next[0] = 1'b1;
         leading = 1'b1;
         for (int i = 1; i <= n; i++) begin
            if (leading && model_pattern[(i-1)*8 +: 8] == STAR_CHAR)
               next[i] = 1'b1;
            else
               leading = 1'b0;
         end
      end else begin
         // one ripple pass, star bits feed upward
         for (int i = 1; i <= n; i++) begin
            pc = model_pattern[(i-1)*8 +: 8];
            if (pc == STAR_CHAR)
               next[i] = match_bits[i] | next[i-1];
            else if (pc == QUESTION_CHAR || pc == ch)
               next[i] = match_bits[i-1];
            else
               next[i] = 1'b0;
         end
      end
      match_bits = next & ({33{1'b1}} >> (MAX_LEN - n));
      verdict.matched = match_bits[n];
      verdict.alive   = |match_bits;
   endtask

   // request driver, also tracks register writes and predicts on accept
   always @(posedge clock) begin : drive_requests
      result_type verdict;
      step_type   step;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
         model_pattern = '0;
         model_length = '0;
         match_bits = 33'h1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_PATTERN_WORD0:  model_pattern[63:0]    = csr_data;
               REG_PATTERN_WORD1:  model_pattern[127:64]  = csr_data;
               REG_PATTERN_WORD2:  model_pattern[191:128] = csr_data;
               REG_PATTERN_WORD3:  model_pattern[255:192] = csr_data;
               REG_PATTERN_LENGTH: model_length = csr_data[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            advance_column(op_type'(req_tuser[0]), req_tdata, verdict);
            expected_verdicts.push_back(verdict);
         end
         // an offered transaction stays put until taken
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (queued_steps.size() > 0 && !calm && $urandom_range(0, 11) == 0) begin
               req_tvalid <= 1'b0;
               send_gap <= $urandom_range(0, 13);
            end else if (queued_steps.size() > 0) begin
               step = queued_steps.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= step.op;
               req_tdata <= step.text_char;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result ready: random bursts plus requested long hold-offs
   always @(posedge clock) begin : drive_sink
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_served != stall_requests) begin
         rsp_tready <= 1'b0;
         stall_left <= STALL_CYCLES;
         stall_served <= stall_requests;
      end else if (sink_gap > 0) begin
         rsp_tready <= 1'b0;
         sink_gap <= sink_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         sink_gap <= $urandom_range(0, 13);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = result_type'(rsp_tdata[1:0]);
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual matched %0b alive %0b",
                     $time, seen.matched, seen.alive);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (seen.matched !== want.matched) begin
               $display("%0t: matched expected %0b actual %0b",
                        $time, want.matched, seen.matched);
               fail_count++;
            end
            if (seen.alive !== want.alive) begin
               $display("%0t: alive expected %0b actual %0b",
                        $time, want.alive, seen.alive);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("wildcard_pattern_matcher: mismatch");
         $finish;
      end
   end

   function automatic void queue_step(input op_type op, input logic [7:0] ch);
      step_type s;
      s.op = op;
      s.text_char = ch;
      queued_steps.push_back(s);
      steps_queued++;
   endfunction

   // mostly pattern alphabet, sometimes any byte
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 7))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return STAR_CHAR;
         4: return QUESTION_CHAR;
         5: return "a";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void set_pattern_text(input string s, input int len);
      stim_pattern = '0;
      for (int k = 0; k < s.len(); k++)
         stim_pattern[k*8 +: 8] = s[k];
      stim_length = len;
   endfunction

   // used bytes from the glob alphabet, unused bytes anything
   function automatic void make_pattern(input int len);
      int used;
      used = (len > MAX_LEN) ? MAX_LEN : len;
      stim_length = len;
      for (int k = 0; k < MAX_LEN; k++) begin
         if (k >= used)
            stim_pattern[k*8 +: 8] = 8'($urandom_range(0, 255));
         else begin
            case ($urandom_range(0, 5))
               0: stim_pattern[k*8 +: 8] = STAR_CHAR;
               1: stim_pattern[k*8 +: 8] = QUESTION_CHAR;
               2: stim_pattern[k*8 +: 8] = "b";
               3: stim_pattern[k*8 +: 8] = "c";
               default: stim_pattern[k*8 +: 8] = "a";
            endcase
         end
      end
   endfunction

   // start plus a text: mostly one that fits the pattern, sometimes spoiled
   function automatic void queue_sequence();
      int         n;
      int         extra;
      logic [7:0] pc;
      n = (stim_length > MAX_LEN) ? MAX_LEN : stim_length;
      queue_step(OP_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 7) begin
         for (int k = 0; k < n; k++) begin
            pc = stim_pattern[k*8 +: 8];
            if (pc == STAR_CHAR) begin
               extra = $urandom_range(0, 3);
               for (int j = 0; j < extra; j++)
                  queue_step(OP_CHAR, pick_char());
            end else if (pc == QUESTION_CHAR || $urandom_range(0, 19) == 0)
               queue_step(OP_CHAR, pick_char());
            else
               queue_step(OP_CHAR, pc);
         end
         if ($urandom_range(0, 3) == 0)
            queue_step(OP_CHAR, pick_char());
      end else begin
         extra = $urandom_range(0, 12);
         for (int j = 0; j < extra; j++)
            queue_step(OP_CHAR, pick_char());
      end
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_pattern();
      write_reg(REG_PATTERN_WORD0, stim_pattern[63:0]);
      write_reg(REG_PATTERN_WORD1, stim_pattern[127:64]);
      write_reg(REG_PATTERN_WORD2, stim_pattern[191:128]);
      write_reg(REG_PATTERN_WORD3, stim_pattern[255:192]);
      write_reg(REG_PATTERN_LENGTH, 64'(stim_length));
      @(negedge clock);
   endtask

   // sender pause: everything offered, taken and answered
   task automatic wait_drained();
      @(negedge clock);
      while (queued_steps.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      int len;
      int phase_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pattern straight after reset, text byte on a start is ignored
      queue_step(OP_START, 8'hA5);
      queue_step(OP_CHAR, 8'h00);
      queue_step(OP_CHAR, 8'hFF);
      queue_step(OP_START, 8'h00);
      wait_drained();

      // leading stars, question mark, star as a text byte
      set_pattern_text("**x?", 4);
      load_pattern();
      queue_step(OP_START, "x");
      queue_step(OP_CHAR, "x");
      queue_step(OP_CHAR, STAR_CHAR);
      queue_step(OP_CHAR, "y");
      queue_step(OP_START, 8'hFF);
      queue_step(OP_CHAR, STAR_CHAR);
      queue_step(OP_CHAR, "x");
      wait_drained();

      // length rewritten in the middle of a text, column carries over
      write_reg(REG_PATTERN_LENGTH, 64'd2);
      @(negedge clock);
      queue_step(OP_CHAR, "q");
      queue_step(OP_CHAR, "x");
      wait_drained();

      // length beyond the maximum, extreme byte values in pattern and text
      stim_pattern = '0;
      for (int k = 1; k < MAX_LEN - 1; k++)
         stim_pattern[k*8 +: 8] = QUESTION_CHAR;
      stim_pattern[15*8 +: 8] = STAR_CHAR;
      stim_pattern[31*8 +: 8] = 8'hFF;
      stim_length = 63;
      load_pattern();
      queue_step(OP_START, 8'h00);
      queue_step(OP_CHAR, 8'h00);
      queue_step(OP_CHAR, 8'hFF);
      queue_step(OP_CHAR, "z");
      queue_step(OP_CHAR, 8'hFF);
      wait_drained();

      // full length of stars only
      set_pattern_text("********************************", MAX_LEN);
      load_pattern();
      queue_step(OP_START, 8'h00);
      queue_step(OP_CHAR, "k");

      // random phases, each with its own pattern
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: len = MAX_LEN;
            1: len = 0;
            2: len = 63;
            3: len = 1;
            4: len = $urandom_range(MAX_LEN + 1, 62);
            default: len = $urandom_range(1, 12);
         endcase
         make_pattern(len);
         load_pattern();
         if (p >= RANDOM_PHASES - 2)
            calm = 1'b1;
         phase_start = steps_queued;
         // some text bytes before the first start of the phase
         if ($urandom_range(0, 2) == 0) begin
            queue_step(OP_CHAR, pick_char());
            queue_step(OP_CHAR, pick_char());
         end
         while (steps_queued - phase_start < PHASE_STEPS / 2)
            queue_sequence();
         // long receiver hold-off while the sender keeps offering
         if (p == 3)
            stall_requests++;
         wait_drained();
         while (steps_queued - phase_start < PHASE_STEPS)
            queue_sequence();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("wildcard_pattern_matcher: match");
      else
         $display("wildcard_pattern_matcher: mismatch");
      $finish;
   end

endmodule

// ----- wildcard_pattern_matcher.f -----
+incdir+hdl
hdl/wpm_pkg.sv
hdl/wpm_csr_regs.sv
hdl/wpm_column_unit.sv
hdl/wildcard_pattern_matcher.sv
hdl/wpm_checker.sv
test/testbench.sv
